[hw/rtl/hngr_pkg.sv]
// Shared constants, register codes, state, command and status types of the assignment solver.
package hngr_pkg;

    localparam int N_MAX_DEF = 32;
    localparam int COST_W    = 29;
    localparam int TOTAL_W   = 35;
    localparam int SIZE_W    = 6;
    localparam int IDX_W     = 5;
    localparam int DW        = 40;
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;

    localparam logic [1:0] REG_MAXIMIZE = 2'd0;
    localparam logic [1:0] REG_ROWS     = 2'd1;
    localparam logic [1:0] REG_COLS     = 2'd2;

    localparam logic [30:0] SLACK_INF = 31'h7FFFFFFF;

    typedef enum logic [5:0] {
        S_IDLE, S_MAX_RD, S_MAX_ACC, S_CM_START, S_CM_RD, S_CM_ACC, S_INIT,
        S_RR_RD, S_RR_ACC, S_RF_RD, S_RF_CHK, S_UM_INIT, S_STG, S_SC_ROW,
        S_SC_RD, S_SC_W, S_SC_ACT, S_DU_START, S_DU_MIN, S_DU_CHK, S_DU_RR,
        S_DU_SL, S_DU_FIX, S_AUG_SET, S_AUG, S_UM_DEC, S_RB_START, S_RB,
        S_CO_START, S_CO_SET, S_CO_RD, S_CO_ACC, S_OUT_START, S_OUT
    } t_state;

    typedef enum logic [4:0] {
        CMD_NOP, CMD_LOAD, CMD_MAX_ACC, CMD_CM_START, CMD_CM_ACC, CMD_INIT,
        CMD_RR_ACC, CMD_RF_CHK, CMD_UM_INIT, CMD_STG, CMD_SC_ROW, CMD_SC_W,
        CMD_SC_ACT, CMD_DU_START, CMD_DU_MIN, CMD_DU_CHK, CMD_DU_RR, CMD_DU_SL,
        CMD_DU_FIX, CMD_AUG_SET, CMD_AUG, CMD_UM_DEC, CMD_RB_START, CMD_RB,
        CMD_CO_START, CMD_CO_SET, CMD_CO_ACC, CMD_OUT_START, CMD_OUT
    } t_cmd;

    typedef struct packed {
        logic maxm;
        logic in_last;
        logic kl_last;
        logic k_last;
        logic l_last;
        logic q_lt_t;
        logic rf_done;
        logic sc_brk;
        logic s_inf;
        logic du_brk;
        logic aug_done;
        logic um_one;
        logic t_zero;
        logic out_free;
    } t_stat;

endpackage

[hw/rtl/hngr_if.sv]
// Valid/ready channel interfaces for cost entries and assignment results.
interface hngr_in_if;
    logic                         valid;
    logic                         ready;
    logic [hngr_pkg::COST_W-1:0]  cost_value;
    logic                         last_entry;

    modport source (output valid, output cost_value, output last_entry, input ready);
    modport sink (input valid, input cost_value, input last_entry, output ready);
endinterface

interface hngr_out_if;
    logic                          valid;
    logic                          ready;
    logic [hngr_pkg::IDX_W-1:0]    row_index;
    logic [hngr_pkg::IDX_W-1:0]    col_index;
    logic                          is_padding;
    logic [hngr_pkg::TOTAL_W-1:0]  total_cost;
    logic                          last_result;

    modport source (output valid, output row_index, output col_index, output is_padding,
                    output total_cost, output last_result, input ready);
    modport sink (input valid, input row_index, input col_index, input is_padding,
                  input total_cost, input last_result, output ready);
endinterface

[hw/rtl/hngr_ctrl.sv]
// Sequencer state machine that steps the solver datapath through its phases.
module hngr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  hngr_pkg::t_stat  i_stat,
    output hngr_pkg::t_cmd   o_cmd
);

    hngr_pkg::t_state r_state;
    hngr_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hngr_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hngr_pkg::S_IDLE: begin
                if (i_stat.in_last) begin
                    n_state = i_stat.maxm ? hngr_pkg::S_MAX_RD : hngr_pkg::S_CM_START;
                end
            end
            hngr_pkg::S_MAX_RD:    n_state = hngr_pkg::S_MAX_ACC;
            hngr_pkg::S_MAX_ACC:   n_state = i_stat.kl_last ? hngr_pkg::S_CM_START
                                                            : hngr_pkg::S_MAX_RD;
            hngr_pkg::S_CM_START:  n_state = hngr_pkg::S_CM_RD;
            hngr_pkg::S_CM_RD:     n_state = hngr_pkg::S_CM_ACC;
            hngr_pkg::S_CM_ACC:    n_state = i_stat.kl_last ? hngr_pkg::S_INIT
                                                            : hngr_pkg::S_CM_RD;
            hngr_pkg::S_INIT:      n_state = hngr_pkg::S_RR_RD;
            hngr_pkg::S_RR_RD:     n_state = hngr_pkg::S_RR_ACC;
            hngr_pkg::S_RR_ACC:    n_state = i_stat.l_last ? hngr_pkg::S_RF_RD
                                                           : hngr_pkg::S_RR_RD;
            hngr_pkg::S_RF_RD:     n_state = hngr_pkg::S_RF_CHK;
            hngr_pkg::S_RF_CHK: begin
                if (!i_stat.rf_done) begin
                    n_state = hngr_pkg::S_RF_RD;
                end else begin
                    n_state = i_stat.k_last ? hngr_pkg::S_UM_INIT : hngr_pkg::S_RR_RD;
                end
            end
            hngr_pkg::S_UM_INIT:   n_state = i_stat.t_zero ? hngr_pkg::S_CO_START
                                                           : hngr_pkg::S_STG;
            hngr_pkg::S_STG:       n_state = hngr_pkg::S_SC_ROW;
            hngr_pkg::S_SC_ROW:    n_state = i_stat.q_lt_t ? hngr_pkg::S_SC_RD
                                                           : hngr_pkg::S_DU_START;
            hngr_pkg::S_SC_RD:     n_state = hngr_pkg::S_SC_W;
            hngr_pkg::S_SC_W:      n_state = hngr_pkg::S_SC_ACT;
            hngr_pkg::S_SC_ACT: begin
                if (i_stat.sc_brk) begin
                    n_state = hngr_pkg::S_AUG_SET;
                end else begin
                    n_state = i_stat.l_last ? hngr_pkg::S_SC_ROW : hngr_pkg::S_SC_RD;
                end
            end
            hngr_pkg::S_DU_START:  n_state = hngr_pkg::S_DU_MIN;
            hngr_pkg::S_DU_MIN:    n_state = i_stat.l_last ? hngr_pkg::S_DU_CHK
                                                           : hngr_pkg::S_DU_MIN;
            hngr_pkg::S_DU_CHK:    n_state = i_stat.s_inf ? hngr_pkg::S_CO_START
                                                          : hngr_pkg::S_DU_RR;
            hngr_pkg::S_DU_RR:     n_state = i_stat.q_lt_t ? hngr_pkg::S_DU_RR
                                                           : hngr_pkg::S_DU_SL;
            hngr_pkg::S_DU_SL: begin
                if (i_stat.du_brk) begin
                    n_state = hngr_pkg::S_DU_FIX;
                end else begin
                    n_state = i_stat.l_last ? hngr_pkg::S_SC_ROW : hngr_pkg::S_DU_SL;
                end
            end
            hngr_pkg::S_DU_FIX:    n_state = i_stat.l_last ? hngr_pkg::S_AUG_SET
                                                           : hngr_pkg::S_DU_FIX;
            hngr_pkg::S_AUG_SET:   n_state = hngr_pkg::S_AUG;
            hngr_pkg::S_AUG:       n_state = i_stat.aug_done ? hngr_pkg::S_UM_DEC
                                                             : hngr_pkg::S_AUG;
            hngr_pkg::S_UM_DEC:    n_state = i_stat.um_one ? hngr_pkg::S_CO_START
                                                           : hngr_pkg::S_RB_START;
            hngr_pkg::S_RB_START:  n_state = hngr_pkg::S_RB;
            hngr_pkg::S_RB:        n_state = i_stat.k_last ? hngr_pkg::S_STG
                                                           : hngr_pkg::S_RB;
            hngr_pkg::S_CO_START:  n_state = hngr_pkg::S_CO_SET;
            hngr_pkg::S_CO_SET:    n_state = hngr_pkg::S_CO_RD;
            hngr_pkg::S_CO_RD:     n_state = hngr_pkg::S_CO_ACC;
            hngr_pkg::S_CO_ACC:    n_state = i_stat.k_last ? hngr_pkg::S_OUT_START
                                                           : hngr_pkg::S_CO_SET;
            hngr_pkg::S_OUT_START: n_state = hngr_pkg::S_OUT;
            hngr_pkg::S_OUT: begin
                if (i_stat.out_free && i_stat.k_last) begin
                    n_state = hngr_pkg::S_IDLE;
                end
            end
            default:               n_state = hngr_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        unique case (r_state)
            hngr_pkg::S_IDLE:      o_cmd = hngr_pkg::CMD_LOAD;
            hngr_pkg::S_MAX_ACC:   o_cmd = hngr_pkg::CMD_MAX_ACC;
            hngr_pkg::S_CM_START:  o_cmd = hngr_pkg::CMD_CM_START;
            hngr_pkg::S_CM_ACC:    o_cmd = hngr_pkg::CMD_CM_ACC;
            hngr_pkg::S_INIT:      o_cmd = hngr_pkg::CMD_INIT;
            hngr_pkg::S_RR_ACC:    o_cmd = hngr_pkg::CMD_RR_ACC;
            hngr_pkg::S_RF_CHK:    o_cmd = hngr_pkg::CMD_RF_CHK;
            hngr_pkg::S_UM_INIT:   o_cmd = hngr_pkg::CMD_UM_INIT;
            hngr_pkg::S_STG:       o_cmd = hngr_pkg::CMD_STG;
            hngr_pkg::S_SC_ROW:    o_cmd = hngr_pkg::CMD_SC_ROW;
            hngr_pkg::S_SC_W:      o_cmd = hngr_pkg::CMD_SC_W;
            hngr_pkg::S_SC_ACT:    o_cmd = hngr_pkg::CMD_SC_ACT;
            hngr_pkg::S_DU_START:  o_cmd = hngr_pkg::CMD_DU_START;
            hngr_pkg::S_DU_MIN:    o_cmd = hngr_pkg::CMD_DU_MIN;
            hngr_pkg::S_DU_CHK:    o_cmd = hngr_pkg::CMD_DU_CHK;
            hngr_pkg::S_DU_RR:     o_cmd = hngr_pkg::CMD_DU_RR;
            hngr_pkg::S_DU_SL:     o_cmd = hngr_pkg::CMD_DU_SL;
            hngr_pkg::S_DU_FIX:    o_cmd = hngr_pkg::CMD_DU_FIX;
            hngr_pkg::S_AUG_SET:   o_cmd = hngr_pkg::CMD_AUG_SET;
            hngr_pkg::S_AUG:       o_cmd = hngr_pkg::CMD_AUG;
            hngr_pkg::S_UM_DEC:    o_cmd = hngr_pkg::CMD_UM_DEC;
            hngr_pkg::S_RB_START:  o_cmd = hngr_pkg::CMD_RB_START;
            hngr_pkg::S_RB:        o_cmd = hngr_pkg::CMD_RB;
            hngr_pkg::S_CO_START:  o_cmd = hngr_pkg::CMD_CO_START;
            hngr_pkg::S_CO_SET:    o_cmd = hngr_pkg::CMD_CO_SET;
            hngr_pkg::S_CO_ACC:    o_cmd = hngr_pkg::CMD_CO_ACC;
            hngr_pkg::S_OUT_START: o_cmd = hngr_pkg::CMD_OUT_START;
            hngr_pkg::S_OUT:       o_cmd = hngr_pkg::CMD_OUT;
            default:               o_cmd = hngr_pkg::CMD_NOP;
        endcase
    end

endmodule

[hw/rtl/hngr_dp.sv]
// Solver datapath: cost memory, dual and slack arrays, matching arrays and result register.
module hngr_dp #(
    parameter int N_MAX = hngr_pkg::N_MAX_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  hngr_pkg::t_cmd                i_cmd,
    output hngr_pkg::t_stat               o_stat,
    input  logic                          i_maximize,
    input  logic [hngr_pkg::SIZE_W-1:0]   i_rows,
    input  logic [hngr_pkg::SIZE_W-1:0]   i_cols,
    hngr_in_if.sink                       i_cost,
    hngr_out_if.source                    o_result
);

    localparam int LW = (N_MAX > 1) ? $clog2(N_MAX) : 1;
    localparam int SW = LW + 1;
    localparam int IW = LW + 1;
    localparam int MW = 2 * LW;
    localparam int CW = 2 * SW;
    localparam int DW = hngr_pkg::DW;
    localparam int COST_W = hngr_pkg::COST_W;
    localparam int TOTAL_W = hngr_pkg::TOTAL_W;
    localparam int IDX_W = hngr_pkg::IDX_W;
    localparam logic signed [DW-1:0] INF_D = $signed({{(DW-31){1'b0}}, hngr_pkg::SLACK_INF});
    localparam logic [IW-1:0] NONE = '1;

    logic [COST_W-1:0]       mem [0:(1 << MW)-1];
    logic [COST_W-1:0]       r_md;
    logic                    r_pad;

    logic signed [DW-1:0]    r_colterm [N_MAX];
    logic signed [DW-1:0]    r_rowred [N_MAX];
    logic signed [DW-1:0]    r_colinc [N_MAX];
    logic signed [DW-1:0]    r_slack [N_MAX];
    logic [LW-1:0]           r_ssrc [N_MAX];
    logic [IW-1:0]           r_parent [N_MAX];
    logic [IW-1:0]           r_mrow [N_MAX];
    logic [IW-1:0]           r_mcol [N_MAX];
    logic [LW-1:0]           r_unch [N_MAX];

    logic [LW-1:0]           r_k;
    logic [LW-1:0]           r_l;
    logic [SW-1:0]           r_qi;
    logic [SW-1:0]           r_t;
    logic [SW-1:0]           r_um;
    logic signed [DW-1:0]    r_s;
    logic signed [DW-1:0]    r_w;
    logic [COST_W-1:0]       r_maxc;
    logic [TOTAL_W-1:0]      r_total;
    logic [LW-1:0]           r_bk;
    logic [LW-1:0]           r_bl;
    logic                    r_cvalid;
    logic                    r_maxm;
    logic [SW-1:0]           r_rows;
    logic [SW-1:0]           r_cols;
    logic [SW-1:0]           r_n;

    logic [LW-1:0]           r_ld_r;
    logic [LW-1:0]           r_ld_c;
    logic [CW-1:0]           r_ld_cnt;

    logic                    r_ov;
    logic [IDX_W-1:0]        r_orow;
    logic [IDX_W-1:0]        r_ocol;
    logic                    r_opad;
    logic [TOTAL_W-1:0]      r_otot;
    logic                    r_olast;

    logic [SW-1:0]           rows_c;
    logic [SW-1:0]           cols_c;
    logic [CW-1:0]           limit;
    logic                    accept;
    logic                    store_en;
    logic [SW-1:0]           n1;
    logic                    k_last;
    logic                    l_last;
    logic [COST_W-1:0]       orig_v;
    logic [COST_W-1:0]       inv_v;
    logic signed [DW-1:0]    orig_d;
    logic signed [DW-1:0]    inv_d;
    logic signed [DW-1:0]    maxc_d;
    logic signed [DW-1:0]    work_v;
    logic signed [DW-1:0]    del;
    logic signed [DW-1:0]    sl;
    logic signed [DW-1:0]    sl_new;
    logic                    sl_nz;
    logic [IW-1:0]           mcol;
    logic                    mcol_none;
    logic [IW-1:0]           mrow_k;
    logic [IW-1:0]           par_j;
    logic [LW-1:0]           uq;
    logic                    q_lt_t;
    logic                    t_room;
    logic                    rf_hit;
    logic                    sc_brk;
    logic                    du_brk;
    logic                    out_free;
    logic [LW-1:0]           oc;
    logic signed [DW-1:0]    cm_m;
    logic signed [DW-1:0]    rr_m;

    always_comb begin
        if (i_rows == '0) begin
            rows_c = SW'(1);
        end else if (int'(i_rows) > N_MAX) begin
            rows_c = SW'(N_MAX);
        end else begin
            rows_c = SW'(i_rows);
        end
        if (i_cols == '0) begin
            cols_c = SW'(1);
        end else if (int'(i_cols) > N_MAX) begin
            cols_c = SW'(N_MAX);
        end else begin
            cols_c = SW'(i_cols);
        end
    end

    assign limit    = CW'(rows_c) * CW'(cols_c);
    assign i_cost.ready = (i_cmd == hngr_pkg::CMD_LOAD);
    assign accept   = i_cost.valid && i_cost.ready;
    assign store_en = accept && (r_ld_cnt < limit);

    assign n1     = r_n - SW'(1);
    assign k_last = ({1'b0, r_k} == n1);
    assign l_last = ({1'b0, r_l} == n1);

    assign orig_v = r_pad ? '0 : r_md;
    assign inv_v  = r_maxm ? (r_maxc - orig_v) : orig_v;
    assign orig_d = $signed({{(DW-COST_W){1'b0}}, orig_v});
    assign inv_d  = $signed({{(DW-COST_W){1'b0}}, inv_v});
    assign maxc_d = $signed({{(DW-COST_W){1'b0}}, r_maxc});
    assign work_v = r_maxm ? (r_colterm[r_l] - orig_d) : (r_colterm[r_l] + orig_d);
    assign del    = r_w - r_s + r_colinc[r_l];

    assign sl        = r_slack[r_l];
    assign sl_nz     = (sl != '0);
    assign sl_new    = sl - r_s;
    assign mcol      = r_mcol[r_l];
    assign mcol_none = mcol[IW-1];
    assign mrow_k    = r_mrow[r_k];
    assign par_j     = r_parent[mrow_k[LW-1:0]];
    assign uq        = r_unch[r_qi[LW-1:0]];
    assign q_lt_t    = (r_qi < r_t);
    assign t_room    = (r_t < SW'(N_MAX));

    assign rf_hit = (work_v == r_s) && mcol_none;
    assign sc_brk = sl_nz && (del < sl) && (del == '0) && mcol_none;
    assign du_brk = sl_nz && (sl_new == '0) && mcol_none;
    assign out_free = !r_ov || o_result.ready;
    assign oc = mrow_k[IW-1] ? '0 : mrow_k[LW-1:0];

    assign cm_m = ((r_k == '0) || (inv_d < r_s)) ? inv_d : r_s;
    assign rr_m = ((r_l == '0) || (work_v < r_s)) ? work_v : r_s;

    always_comb begin
        o_stat.maxm     = i_maximize;
        o_stat.in_last  = accept && i_cost.last_entry;
        o_stat.kl_last  = k_last && l_last;
        o_stat.k_last   = k_last;
        o_stat.l_last   = l_last;
        o_stat.q_lt_t   = q_lt_t;
        o_stat.rf_done  = rf_hit || l_last;
        o_stat.sc_brk   = sc_brk;
        o_stat.s_inf    = (r_s == INF_D);
        o_stat.du_brk   = du_brk;
        o_stat.aug_done = mrow_k[IW-1] || par_j[IW-1];
        o_stat.um_one   = (r_um == SW'(1));
        o_stat.t_zero   = (r_t == '0);
        o_stat.out_free = out_free;
    end

    always_ff @(posedge i_clk) begin
        if (store_en) begin
            mem[{r_ld_r, r_ld_c}] <= i_cost.cost_value;
        end
        r_md  <= mem[{r_k, r_l}];
        r_pad <= !(({1'b0, r_k} < r_rows) && ({1'b0, r_l} < r_cols));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ld_r   <= '0;
            r_ld_c   <= '0;
            r_ld_cnt <= '0;
            r_ov     <= 1'b0;
        end else begin
            if (accept && i_cost.last_entry) begin
                r_ld_r   <= '0;
                r_ld_c   <= '0;
                r_ld_cnt <= '0;
            end else if (store_en) begin
                r_ld_cnt <= r_ld_cnt + CW'(1);
                if ({1'b0, r_ld_c} == cols_c - SW'(1)) begin
                    r_ld_c <= '0;
                    r_ld_r <= r_ld_r + LW'(1);
                end else begin
                    r_ld_c <= r_ld_c + LW'(1);
                end
            end
            if (i_cmd == hngr_pkg::CMD_OUT && out_free) begin
                r_ov <= 1'b1;
            end else if (o_result.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd)
            hngr_pkg::CMD_LOAD: begin
                if (accept && i_cost.last_entry) begin
                    r_rows <= rows_c;
                    r_cols <= cols_c;
                    r_n    <= (rows_c > cols_c) ? rows_c : cols_c;
                    r_maxm <= i_maximize;
                    r_maxc <= '0;
                    r_k    <= '0;
                    r_l    <= '0;
                end
            end
            hngr_pkg::CMD_MAX_ACC: begin
                if (orig_v > r_maxc) begin
                    r_maxc <= orig_v;
                end
                if (l_last) begin
                    r_l <= '0;
                    r_k <= r_k + LW'(1);
                end else begin
                    r_l <= r_l + LW'(1);
                end
            end
            hngr_pkg::CMD_CM_START: begin
                r_k <= '0;
                r_l <= '0;
            end
            hngr_pkg::CMD_CM_ACC: begin
                if (k_last) begin
                    r_colterm[r_l] <= r_maxm ? (maxc_d - cm_m) : -cm_m;
                    r_k <= '0;
                    r_l <= r_l + LW'(1);
                end else begin
                    r_s <= cm_m;
                    r_k <= r_k + LW'(1);
                end
            end
            hngr_pkg::CMD_INIT: begin
                for (int i = 0; i < N_MAX; i++) begin
                    r_mcol[i]   <= NONE;
                    r_parent[i] <= NONE;
                    r_colinc[i] <= '0;
                    r_slack[i]  <= INF_D;
                    r_ssrc[i]   <= '0;
                end
                r_t <= '0;
                r_k <= '0;
                r_l <= '0;
            end
            hngr_pkg::CMD_RR_ACC: begin
                r_s <= rr_m;
                if (l_last) begin
                    r_rowred[r_k] <= rr_m;
                    r_l <= '0;
                end else begin
                    r_l <= r_l + LW'(1);
                end
            end
            hngr_pkg::CMD_RF_CHK: begin
                if (rf_hit) begin
                    r_mrow[r_k] <= IW'(r_l);
                    r_mcol[r_l] <= IW'(r_k);
                end else if (l_last) begin
                    r_mrow[r_k] <= NONE;
                    r_unch[r_t[LW-1:0]] <= r_k;
                    r_t <= r_t + SW'(1);
                end
                if (rf_hit || l_last) begin
                    r_l <= '0;
                    r_k <= r_k + LW'(1);
                end else begin
                    r_l <= r_l + LW'(1);
                end
            end
            hngr_pkg::CMD_UM_INIT: begin
                r_um <= r_t;
            end
            hngr_pkg::CMD_STG: begin
                r_qi <= '0;
            end
            hngr_pkg::CMD_SC_ROW: begin
                r_k <= uq;
                r_s <= r_rowred[uq];
                r_l <= '0;
            end
            hngr_pkg::CMD_SC_W: begin
                r_w <= work_v;
            end
            hngr_pkg::CMD_SC_ACT: begin
                if (sl_nz && (del < sl)) begin
                    if (del == '0) begin
                        if (mcol_none) begin
                            r_bk <= r_k;
                            r_bl <= r_l;
                        end else begin
                            r_slack[r_l]  <= '0;
                            r_parent[r_l] <= IW'(r_k);
                            if (t_room) begin
                                r_unch[r_t[LW-1:0]] <= mcol[LW-1:0];
                                r_t <= r_t + SW'(1);
                            end
                        end
                    end else begin
                        r_slack[r_l] <= del;
                        r_ssrc[r_l]  <= r_k;
                    end
                end
                if (!sc_brk) begin
                    if (l_last) begin
                        r_qi <= r_qi + SW'(1);
                    end else begin
                        r_l <= r_l + LW'(1);
                    end
                end
            end
            hngr_pkg::CMD_DU_START: begin
                r_l <= '0;
                r_s <= INF_D;
            end
            hngr_pkg::CMD_DU_MIN: begin
                if (sl_nz && (sl < r_s)) begin
                    r_s <= sl;
                end
                if (!l_last) begin
                    r_l <= r_l + LW'(1);
                end
            end
            hngr_pkg::CMD_DU_CHK: begin
                r_qi <= '0;
            end
            hngr_pkg::CMD_DU_RR: begin
                if (q_lt_t) begin
                    r_rowred[uq] <= r_rowred[uq] + r_s;
                    r_qi <= r_qi + SW'(1);
                end else begin
                    r_l <= '0;
                end
            end
            hngr_pkg::CMD_DU_SL: begin
                if (sl_nz) begin
                    r_slack[r_l] <= sl_new;
                    if (sl_new == '0) begin
                        if (mcol_none) begin
                            r_bk <= r_ssrc[r_l];
                            r_bl <= r_l;
                        end else begin
                            r_parent[r_l] <= IW'(r_ssrc[r_l]);
                            if (t_room) begin
                                r_unch[r_t[LW-1:0]] <= mcol[LW-1:0];
                                r_t <= r_t + SW'(1);
                            end
                        end
                    end
                end else begin
                    r_colinc[r_l] <= r_colinc[r_l] + r_s;
                end
                if (!du_brk && !l_last) begin
                    r_l <= r_l + LW'(1);
                end
            end
            hngr_pkg::CMD_DU_FIX: begin
                if ((r_l != r_bl) && !sl_nz) begin
                    r_colinc[r_l] <= r_colinc[r_l] + r_s;
                end
                if (!l_last) begin
                    r_l <= r_l + LW'(1);
                end
            end
            hngr_pkg::CMD_AUG_SET: begin
                r_k <= r_bk;
                r_l <= r_bl;
            end
            hngr_pkg::CMD_AUG: begin
                r_mrow[r_k] <= IW'(r_l);
                r_mcol[r_l] <= IW'(r_k);
                if (!mrow_k[IW-1] && !par_j[IW-1]) begin
                    r_k <= par_j[LW-1:0];
                    r_l <= mrow_k[LW-1:0];
                end
            end
            hngr_pkg::CMD_UM_DEC: begin
                r_um <= r_um - SW'(1);
            end
            hngr_pkg::CMD_RB_START: begin
                for (int i = 0; i < N_MAX; i++) begin
                    r_parent[i] <= NONE;
                    r_slack[i]  <= INF_D;
                end
                r_t <= '0;
                r_k <= '0;
            end
            hngr_pkg::CMD_RB: begin
                if (mrow_k[IW-1]) begin
                    r_unch[r_t[LW-1:0]] <= r_k;
                    r_t <= r_t + SW'(1);
                end
                if (!k_last) begin
                    r_k <= r_k + LW'(1);
                end
            end
            hngr_pkg::CMD_CO_START: begin
                r_k     <= '0;
                r_total <= '0;
            end
            hngr_pkg::CMD_CO_SET: begin
                r_l      <= mrow_k[LW-1:0];
                r_cvalid <= !mrow_k[IW-1];
            end
            hngr_pkg::CMD_CO_ACC: begin
                if (r_cvalid) begin
                    r_total <= r_total + TOTAL_W'(inv_v);
                end
                if (!k_last) begin
                    r_k <= r_k + LW'(1);
                end
            end
            hngr_pkg::CMD_OUT_START: begin
                r_k <= '0;
            end
            hngr_pkg::CMD_OUT: begin
                if (out_free) begin
                    r_orow  <= IDX_W'(r_k);
                    r_ocol  <= IDX_W'(oc);
                    r_opad  <= ({1'b0, r_k} >= r_rows) || ({1'b0, oc} >= r_cols);
                    r_otot  <= r_total;
                    r_olast <= k_last;
                    if (!k_last) begin
                        r_k <= r_k + LW'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_result.valid       = r_ov;
    assign o_result.row_index   = r_orow;
    assign o_result.col_index   = r_ocol;
    assign o_result.is_padding  = r_opad;
    assign o_result.total_cost  = r_otot;
    assign o_result.last_result = r_olast;

endmodule

[hw/rtl/hungarian_assignment_solver.sv]
// Top level of the Hungarian minimum- or maximum-cost assignment solver with its register port.
//
// Cost entries arrive on i_cost in row-major order, one beat per cycle while the
// block is loading; the beat with last_entry set starts the solve. Size and mode
// come from three registers written over the APB port; the user writes them
// only while the block is idle, which the block itself does not enforce. The
// matrix is padded to a square of side n = max(rows, cols) with zeros. The solve
// steps through the cost memory one entry per cell visit: a max pass (maximize
// only), the column-minimum pass, the row pass, and augmenting stages that each
// scan cells plus run dual and rebuild sweeps, all paced by the single read port
// of the cost memory.
// After the cost sum, o_result delivers n beats, one per row, at
// up to one beat per cycle through an output register; a stalled receiver holds
// the register and the sequencer waits. i_cost is not ready from the last entry
// until the final result beat sits in the output register.
// Reset returns the registers to minimize and 1 by 1, and clears the load
// position and the output valid; the cost memory is not cleared.
module hungarian_assignment_solver #(
    parameter int N_MAX = hngr_pkg::N_MAX_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    hngr_in_if.sink                        i_cost,
    hngr_out_if.source                     o_result,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [hngr_pkg::ADDR_W-1:0]    paddr,
    input  logic [hngr_pkg::DATA_W-1:0]    pwdata,
    output logic [hngr_pkg::DATA_W-1:0]    prdata,
    output logic                           pready
);

    logic                          r_maximize;
    logic [hngr_pkg::SIZE_W-1:0]   r_rows;
    logic [hngr_pkg::SIZE_W-1:0]   r_cols;
    logic [1:0]                    reg_sel;
    hngr_pkg::t_cmd                cmd;
    hngr_pkg::t_stat               stat;

    assign pready  = 1'b1;
    assign reg_sel = paddr[hngr_pkg::ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_maximize <= 1'b0;
            r_rows     <= hngr_pkg::SIZE_W'(1);
            r_cols     <= hngr_pkg::SIZE_W'(1);
        end else if (psel && penable && pwrite) begin
            unique case (reg_sel)
                hngr_pkg::REG_MAXIMIZE: r_maximize <= pwdata[0];
                hngr_pkg::REG_ROWS:     r_rows <= pwdata[hngr_pkg::SIZE_W-1:0];
                hngr_pkg::REG_COLS:     r_cols <= pwdata[hngr_pkg::SIZE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            hngr_pkg::REG_MAXIMIZE: prdata = hngr_pkg::DATA_W'(r_maximize);
            hngr_pkg::REG_ROWS:     prdata = hngr_pkg::DATA_W'(r_rows);
            hngr_pkg::REG_COLS:     prdata = hngr_pkg::DATA_W'(r_cols);
            default:                prdata = '0;
        endcase
    end

    hngr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    hngr_dp #(
        .N_MAX (N_MAX)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_maximize (r_maximize),
        .i_rows     (r_rows),
        .i_cols     (r_cols),
        .i_cost     (i_cost),
        .o_result   (o_result)
    );

endmodule

[hw/rtl/hngr_checker.sv]
// Port-level checks of the solver's channels, bound to the top level.
module hngr_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_in_last,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("Result beat dropped while stalled.");

    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("Result valid after reset.");

    a_busy_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_last |=> !i_in_ready)
        else $error("Input taken while solving.");

    a_busy_while_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_last |-> !i_in_ready)
        else $error("Input taken before the final result beat.");

endmodule

bind hungarian_assignment_solver hngr_checker u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_cost.valid),
    .i_in_ready  (i_cost.ready),
    .i_in_last   (i_cost.last_entry),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_last  (o_result.last_result)
);
